// ===== rtl/core/assert_macros.svh =====
// assertion helpers shared by the display scan modules
// each expects i_clk and i_rst_n in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define CHK_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHK_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CHK_IMP(lbl, ante, cons, msg)
`define CHK_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/core/ttds_pkg.sv =====
package ttds_pkg;

    // widths fixed by the item and result fields
    localparam int MV_W      = 11;
    localparam int DEG_W     = 10;
    localparam int SEG_W     = 8;
    localparam int SEL_W     = 3;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 8;

    localparam int DIGIT_COUNT_DEF = 3;

    localparam logic [DEG_W-1:0] MAX_DEGREES = 10'd999;
    localparam logic [MV_W-1:0]  MV_OFFSET   = 11'd500;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DWELL  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROUNDS = 8'd1;

    localparam logic [CFG_W-1:0] DWELL_RESET  = 8'd1;
    localparam logic [CFG_W-1:0] ROUNDS_RESET = 8'd100;

    localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;

    typedef struct packed {
        logic            func;
        logic [MV_W-1:0] millivolts;
    } t_item;

    typedef struct packed {
        logic [CFG_W-1:0] dwell_ticks;
        logic [CFG_W-1:0] refresh_rounds;
    } t_cfg;

    typedef struct packed {
        logic [SEL_W-1:0] digit_select;
        logic [SEG_W-1:0] segments;
        logic [DEG_W-1:0] held_degrees;
    } t_result;

    typedef struct packed {
        logic [3:0] hundreds;
        logic [3:0] tens;
        logic [3:0] ones;
    } t_dec3;

    // decimal digits of a value below 1000 by reciprocal multiplies
    function automatic t_dec3 dec3(input logic [DEG_W-1:0] v);
        logic [15:0] prod_h;
        logic [9:0]  hx;
        logic [9:0]  rem10;
        logic [6:0]  rem;
        logic [14:0] prod_t;
        logic [6:0]  tx;
        logic [6:0]  o_sub;
        t_dec3       d;
        prod_h     = {6'd0, v} * 16'd41;
        d.hundreds = prod_h[15:12];
        hx         = 10'(d.hundreds) * 10'd100;
        rem10      = v - hx;
        rem        = rem10[6:0];
        prod_t     = {8'd0, rem} * 15'd205;
        d.tens     = prod_t[14:11];
        tx         = 7'(d.tens) * 7'd10;
        o_sub      = rem - tx;
        d.ones     = o_sub[3:0];
        return d;
    endfunction

    // seven-segment pattern, segment a in bit 7, point off
    function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] d);
        logic [SEG_W-1:0] s;
        unique case (d)
            4'd0:    s = 8'hFC;
            4'd1:    s = 8'h60;
            4'd2:    s = 8'hDA;
            4'd3:    s = 8'hF2;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'hB6;
            4'd6:    s = 8'hBE;
            4'd7:    s = 8'hE0;
            4'd8:    s = 8'hFE;
            4'd9:    s = 8'hF6;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/core/ttds_conv.sv =====
module ttds_conv
    import ttds_pkg::*;
(
    input  logic [MV_W-1:0]  i_millivolts,
    output logic [DEG_W-1:0] o_degrees
);

    logic [MV_W-1:0]  above;
    logic [23:0]      prod;
    logic [DEG_W-1:0] quot;

    // (mv - 500) / 10 via multiply by 6554 / 2^16, exact below 16384
    always_comb begin
        above = (i_millivolts > MV_OFFSET) ? (i_millivolts - MV_OFFSET) : '0;
        prod  = {13'd0, above} * 24'd6554;
        quot  = {2'b00, prod[23:16]};
        o_degrees = (quot > MAX_DEGREES) ? MAX_DEGREES : quot;
    end

endmodule

// ===== rtl/core/ttds_scan.sv =====
`include "assert_macros.svh"

module ttds_scan
    import ttds_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
)
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(DIGIT_COUNT - 1);

    logic [DEG_W-1:0] r_held,      n_held;
    logic [3:0]       r_shown [DIGIT_COUNT];
    logic [3:0]       n_shown [DIGIT_COUNT];
    logic [3:0]       fresh   [DIGIT_COUNT];
    logic [POS_W-1:0] r_pos,       n_pos;
    logic [CFG_W-1:0] r_dwell_cnt, n_dwell_cnt;
    logic [CFG_W-1:0] r_round_cnt, n_round_cnt;

    logic [DEG_W-1:0] deg;
    t_dec3            dec;
    logic             frame_start;
    logic             tick;
    logic [3:0]       digit;
    logic [CFG_W-1:0] dwell_inc;
    logic [CFG_W-1:0] round_inc;

    ttds_conv u_conv (
        .i_millivolts (i_item.millivolts),
        .o_degrees    (deg)
    );

    // digits that a frame start would load
    always_comb begin
        int k;
        dec = dec3(r_held);
        for (int p = 0; p < DIGIT_COUNT; p++) begin
            k = DIGIT_COUNT - 1 - p;
            if (k == 0)
                fresh[p] = dec.ones;
            else if (k == 1)
                fresh[p] = dec.tens;
            else if (k == 2)
                fresh[p] = dec.hundreds;
            else
                fresh[p] = 4'd0;
        end
    end

    // result and next scan state
    always_comb begin
        tick        = i_step && !i_item.func;
        frame_start = (r_pos == '0) && (r_dwell_cnt == '0) && (r_round_cnt == '0);

        for (int p = 0; p < DIGIT_COUNT; p++)
            n_shown[p] = (tick && frame_start) ? fresh[p] : r_shown[p];

        digit = n_shown[r_pos];

        for (int b = 0; b < SEL_W; b++)
            o_res.digit_select[b] = (int'(r_pos) == b);
        o_res.segments     = seg_code(digit);
        o_res.held_degrees = (i_step && i_item.func) ? deg : r_held;

        n_held      = o_res.held_degrees;
        n_pos       = r_pos;
        n_dwell_cnt = r_dwell_cnt;
        n_round_cnt = r_round_cnt;
        dwell_inc   = r_dwell_cnt + 8'd1;
        round_inc   = r_round_cnt + 8'd1;

        // dwell, then position, then round counting
        if (tick) begin
            if (dwell_inc >= i_cfg.dwell_ticks) begin
                n_dwell_cnt = '0;
                if (r_pos == POS_LAST) begin
                    n_pos = '0;
                    n_round_cnt = (round_inc >= i_cfg.refresh_rounds) ? '0 : round_inc;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end else begin
                n_dwell_cnt = dwell_inc;
            end
        end
    end

    // scan state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_pos       <= '0;
            r_dwell_cnt <= '0;
            r_round_cnt <= '0;
            for (int p = 0; p < DIGIT_COUNT; p++)
                r_shown[p] <= 4'd0;
        end else begin
            r_held      <= n_held;
            r_pos       <= n_pos;
            r_dwell_cnt <= n_dwell_cnt;
            r_round_cnt <= n_round_cnt;
            for (int p = 0; p < DIGIT_COUNT; p++)
                r_shown[p] <= n_shown[p];
        end
    end

    `CHK_IMP(a_pos_range, 1'b1, int'(r_pos) <= DIGIT_COUNT - 1, "scan position out of range")
    `CHK_IMP(a_held_range, 1'b1, r_held <= MAX_DEGREES, "held value above saturation")
    `CHK_NXT(a_sample_no_scan, i_step && i_item.func, $stable(r_pos) && $stable(r_dwell_cnt), "sample moved the scan")

endmodule

// ===== rtl/core/temp_to_three_digit_display_scan.sv =====
// Scanned three-digit seven-segment temperature display. A sample transfer
// (func 1) converts millivolts to whole degrees as (mv - 500) / 10, clamped
// to 0..999, and holds it; a tick transfer (func 0) lights one digit
// position with its segment pattern and advances the scan after dwell_ticks
// ticks per position. Digits reload from the held value only at the start of
// each frame of refresh_rounds rounds. Every transfer in gives one result.
// One item is taken per clock: it passes an input register and then a result
// register, from which its result is offered, and the input keeps flowing
// while the result register is free or being emptied. Write configuration
// only while the block is idle; the config port is always ready.
`include "assert_macros.svh"

module temp_to_three_digit_display_scan
    import ttds_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_in_func,
    input  logic [MV_W-1:0]      i_in_millivolts,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [SEL_W-1:0]     o_out_digit_select,
    output logic [SEG_W-1:0]     o_out_segments,
    output logic [DEG_W-1:0]     o_out_held_degrees,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic    r_in_vld;
    t_item   r_in;
    logic    r_out_vld;
    t_result r_out;
    t_cfg    r_cfg;
    t_result res;
    logic    advance;
    logic    step;
    logic    in_take;

    // handshake between the two register stages
    assign advance    = !r_out_vld || !i_out_stall;
    assign step       = r_in_vld && advance;
    assign o_in_stall = r_in_vld && !advance;
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dwell_ticks    <= DWELL_RESET;
            r_cfg.refresh_rounds <= ROUNDS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_DWELL:  r_cfg.dwell_ticks    <= i_cfg_data;
                REG_ROUNDS: r_cfg.refresh_rounds <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_in_vld <= 1'b0;
        else if (in_take)
            r_in_vld <= 1'b1;
        else if (step)
            r_in_vld <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.func       <= i_in_func;
            r_in.millivolts <= i_in_millivolts;
        end
    end

    ttds_scan #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_vld <= 1'b0;
        else if (advance)
            r_out_vld <= step;
    end

    always_ff @(posedge i_clk) begin
        if (step)
            r_out <= res;
    end

    assign o_out_valid        = r_out_vld;
    assign o_out_digit_select = r_out.digit_select;
    assign o_out_segments     = r_out.segments;
    assign o_out_held_degrees = r_out.held_degrees;

    `CHK_IMP(a_sel_onehot, r_out_vld, $onehot0(r_out.digit_select), "digit select not one-hot")
    `CHK_IMP(a_out_held_range, r_out_vld, r_out.held_degrees <= MAX_DEGREES, "result degrees above 999")
    `CHK_NXT(a_step_lands, step, r_out_vld, "processed item did not reach the result register")

endmodule
